// ----- hdl/mmes_pkg.sv -----
// ----------------------------------------------------------------------------
// mmes_pkg: shared types and constants for the min multiset sweep engine
// Request kinds, result status codes, cell control type and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package mmes_pkg;

  // Default sizes
  localparam int CAPACITY_DEF   = 256;
  localparam int VALUE_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed port widths
  localparam int REQ_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;

  // Cells per group in the match reduction
  localparam int GROUP_SIZE = 16;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MIN     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

  // Update applied to the chain
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_INC    = 3'd1,
    OP_DEC    = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } cell_op_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic     cmp_en;
    cell_op_t op;
  } cell_ctl_t;

  // Match flags a cell reports in the compare cycle
  typedef struct packed {
    logic eq;
    logic sat;
    logic one;
  } cell_flag_t;

endpackage

`default_nettype wire

// ----- hdl/mmes_cell.sv -----
// ----------------------------------------------------------------------------
// mmes_cell: one entry of the sorted value chain
// Holds a value with its copy count, compares against the broadcast value
// and shifts data to or from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

module mmes_cell #(
  parameter int VALUE_BITS = mmes_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = mmes_pkg::COUNT_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  mmes_pkg::cell_ctl_t         ctl,
  input  wire  [VALUE_BITS-1:0]       cmp_value,
  input  wire                         left_valid,
  input  wire  [VALUE_BITS-1:0]       left_value,
  input  wire  [COUNT_BITS-1:0]       left_count,
  input  wire                         left_lt,
  input  wire                         right_valid,
  input  wire  [VALUE_BITS-1:0]       right_value,
  input  wire  [COUNT_BITS-1:0]       right_count,
  output logic                        valid,
  output logic [VALUE_BITS-1:0]       value,
  output logic [COUNT_BITS-1:0]       count,
  output logic                        lt,
  output mmes_pkg::cell_flag_t        flags
);
  import mmes_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  lt_r, lt_nxt;
  logic                  eq_r, eq_nxt;
  logic                  eq_now;
  logic                  lt_now;
  logic                  at_pos;

  // Compare against the broadcast value
  assign eq_now = valid_r && (value_r == cmp_value);
  assign lt_now = valid_r && (value_r < cmp_value);

  assign flags.eq  = eq_now;
  assign flags.sat = eq_now && (&count_r);
  assign flags.one = eq_now && (count_r == COUNT_BITS'(1));

  // Hold the compare result for the update cycle
  assign lt_nxt = ctl.cmp_en ? lt_now : lt_r;
  assign eq_nxt = ctl.cmp_en ? eq_now : eq_r;

  // This cell is the first one not below the value
  assign at_pos = !lt_r && left_lt;

  // Apply the update: count change in place, or shift along the chain
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    count_nxt = count_r;
    case (ctl.op)
      OP_INC: begin
        if (eq_r) count_nxt = count_r + COUNT_BITS'(1);
      end
      OP_DEC: begin
        if (eq_r) count_nxt = count_r - COUNT_BITS'(1);
      end
      OP_INSERT: begin
        if (at_pos) begin
          valid_nxt = 1'b1;
          value_nxt = cmp_value;
          count_nxt = COUNT_BITS'(1);
        end else if (!lt_r) begin
          valid_nxt = left_valid;
          value_nxt = left_value;
          count_nxt = left_count;
        end
      end
      OP_DELETE: begin
        if (!lt_r) begin
          valid_nxt = right_valid;
          value_nxt = right_value;
          count_nxt = right_count;
        end
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    count_r <= count_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;
  assign count = count_r;
  assign lt    = lt_r;

endmodule

`default_nettype wire

// ----- hdl/min_multiset_event_sweep_top.sv -----
// ----------------------------------------------------------------------------
// min_multiset_event_sweep_top: sorted multiset with minimum query
// Chain of cells keeps distinct values ascending with copy counts; insert,
// remove and query requests each give one result.
// ----------------------------------------------------------------------------
// The result strobes on out_valid from a register loaded in the update state.
// A new request is accepted only while idle; the accept cycle compares in all
// cells, the next cycle reduces the match flags and shifts the chain.
// busy is high only in the update cycle; results cannot be stalled.
// Reset (synchronous, rst_n low) empties the chain at once; no clearing pass.
`default_nettype none

module min_multiset_event_sweep_top #(
  parameter int CAPACITY   = mmes_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = mmes_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = mmes_pkg::COUNT_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire  [mmes_pkg::REQ_W-1:0]     in_req_type,
  input  wire  [mmes_pkg::DATA_W-1:0]    in_value,
  output logic                           out_valid,
  output logic [mmes_pkg::STATUS_W-1:0]  out_status,
  output logic [mmes_pkg::DATA_W-1:0]    out_min_value
);
  import mmes_pkg::*;

  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic                  accept;
  logic [REQ_W-1:0]      req_type_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [VALUE_BITS-1:0] in_value_conv;
  logic [VALUE_BITS-1:0] cmp_value;
  logic [DATA_W-1:0]     min_conv;
  cell_ctl_t             ctl;
  cell_op_t              op;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, status_nxt;
  logic [DATA_W-1:0]     out_min_value_r, min_nxt;

  // Per-cell views, each read at its own fixed place
  logic [CAPACITY-1:0]   valid_v;
  logic [CAPACITY-1:0]   lt_v;
  logic [CAPACITY-1:0]   eq_v;
  logic [CAPACITY-1:0]   sat_v;
  logic [CAPACITY-1:0]   one_v;
  logic [VALUE_BITS-1:0] value_a [CAPACITY];
  logic [COUNT_BITS-1:0] count_a [CAPACITY];
  cell_flag_t            flag_a  [CAPACITY];

  logic [NUM_GROUPS-1:0] grp_eq_r, grp_eq_nxt;
  logic [NUM_GROUPS-1:0] grp_sat_r, grp_sat_nxt;
  logic [NUM_GROUPS-1:0] grp_one_r, grp_one_nxt;

  logic found, sat, one, full, empty;

  assign busy   = (state_r == S_UPDATE);
  assign accept = start && !busy;

  // Fit the request value to the stored width
  generate
    if (VALUE_BITS <= DATA_W) begin : g_in_narrow
      assign in_value_conv = in_value[VALUE_BITS-1:0];
    end else begin : g_in_wide
      assign in_value_conv = {{(VALUE_BITS-DATA_W){1'b0}}, in_value};
    end
    if (VALUE_BITS >= DATA_W) begin : g_min_narrow
      assign min_conv = value_a[0][DATA_W-1:0];
    end else begin : g_min_wide
      assign min_conv = {{(DATA_W-VALUE_BITS){1'b0}}, value_a[0]};
    end
  endgenerate

  // Compare with the incoming value on accept, the held one while updating
  assign cmp_value  = busy ? value_r : in_value_conv;
  assign ctl.cmp_en = accept;
  assign ctl.op     = busy ? op : OP_NONE;

  // Build the cell chain
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  l_valid, l_lt, r_valid;
      logic [VALUE_BITS-1:0] l_value, r_value;
      logic [COUNT_BITS-1:0] l_count, r_count;

      if (i == 0) begin : g_left_edge
        assign l_valid = 1'b0;
        assign l_value = '0;
        assign l_count = '0;
        assign l_lt    = 1'b1;
      end else begin : g_left
        assign l_valid = valid_v[i-1];
        assign l_value = value_a[i-1];
        assign l_count = count_a[i-1];
        assign l_lt    = lt_v[i-1];
      end

      if (i == CAPACITY - 1) begin : g_right_edge
        assign r_valid = 1'b0;
        assign r_value = '0;
        assign r_count = '0;
      end else begin : g_right
        assign r_valid = valid_v[i+1];
        assign r_value = value_a[i+1];
        assign r_count = count_a[i+1];
      end

      mmes_cell #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cmp_value   (cmp_value),
        .left_valid  (l_valid),
        .left_value  (l_value),
        .left_count  (l_count),
        .left_lt     (l_lt),
        .right_valid (r_valid),
        .right_value (r_value),
        .right_count (r_count),
        .valid       (valid_v[i]),
        .value       (value_a[i]),
        .count       (count_a[i]),
        .lt          (lt_v[i]),
        .flags       (flag_a[i])
      );

      assign eq_v[i]  = flag_a[i].eq;
      assign sat_v[i] = flag_a[i].sat;
      assign one_v[i] = flag_a[i].one;
    end
  endgenerate

  // First level of the match reduction, registered per group
  genvar g;
  generate
    for (g = 0; g < NUM_GROUPS; g++) begin : g_group
      localparam int LO = g * GROUP_SIZE;
      localparam int HI = ((g + 1) * GROUP_SIZE > CAPACITY) ?
                          CAPACITY - 1 : (g + 1) * GROUP_SIZE - 1;
      assign grp_eq_nxt[g]  = accept ? |eq_v[HI:LO]  : grp_eq_r[g];
      assign grp_sat_nxt[g] = accept ? |sat_v[HI:LO] : grp_sat_r[g];
      assign grp_one_nxt[g] = accept ? |one_v[HI:LO] : grp_one_r[g];
    end
  endgenerate

  assign found = |grp_eq_r;
  assign sat   = |grp_sat_r;
  assign one   = |grp_one_r;
  assign full  = valid_v[CAPACITY-1];
  assign empty = !valid_v[0];

  // Decide the chain update and the result
  always_comb begin
    op         = OP_NONE;
    status_nxt = ST_DONE;
    min_nxt    = '0;
    case (req_type_r)
      REQ_INSERT: begin
        if (found) begin
          if (sat) status_nxt = ST_FULL;
          else     op = OP_INC;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op = OP_INSERT;
        end
      end
      REQ_REMOVE: begin
        if (!found)   status_nxt = ST_MISSING;
        else if (one) op = OP_DELETE;
        else          op = OP_DEC;
      end
      REQ_QUERY: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt = ST_MIN;
          min_nxt    = min_conv;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Advance the sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk) begin
    grp_eq_r  <= grp_eq_nxt;
    grp_sat_r <= grp_sat_nxt;
    grp_one_r <= grp_one_nxt;
    if (accept) begin
      req_type_r <= in_req_type;
      value_r    <= in_value_conv;
    end
    if (busy) begin
      out_status_r    <= status_nxt;
      out_min_value_r <= min_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_min_value = out_min_value_r;

endmodule

`default_nettype wire

// ----- hdl/mmes_checker.sv -----
// ----------------------------------------------------------------------------
// mmes_checker: port-level checks for the min multiset sweep engine
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mmes_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           start,
  input wire                           busy,
  input wire                           out_valid,
  input wire [mmes_pkg::STATUS_W-1:0]  out_status,
  input wire [mmes_pkg::DATA_W-1:0]    out_min_value
);
  import mmes_pkg::*;

  // An accepted request holds the engine busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted request");

  // Every accepted request strobes one result after its update cycle
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing two cycles after request");

  // A result never shows while a request is still in update
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  // Status code stays within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_MIN ||
                   out_status == ST_EMPTY || out_status == ST_FULL ||
                   out_status == ST_MISSING))
    else $error("undefined status code");

  // Only a valid minimum carries a nonzero value
  a_min_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_MIN) |-> (out_min_value == '0))
    else $error("nonzero min_value without a valid minimum");

endmodule

bind min_multiset_event_sweep_top mmes_checker u_mmes_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_min_value (out_min_value)
);

`default_nettype wire
